// File: hw/rtl/tbvc_pkg.sv
`default_nettype none

package tbvc_pkg;

	// Field and register geometry
	localparam int unsigned FIX_W      = 32;
	localparam int unsigned CFG_W      = 64;
	localparam int unsigned ADDR_W     = 6;
	localparam int unsigned BYTE_OFS_W = 3;
	localparam int unsigned REG_IDX_W  = ADDR_W - BYTE_OFS_W;

	// Default arithmetic geometry
	localparam int unsigned COORD_BITS_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	typedef logic signed [FIX_W-1:0] fix_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// Register map, one 64-bit register every eight bytes
	localparam reg_idx_t REG_ROW_X_XY   = reg_idx_t'(0);
	localparam reg_idx_t REG_ROW_X_ZW   = reg_idx_t'(1);
	localparam reg_idx_t REG_ROW_Y_XY   = reg_idx_t'(2);
	localparam reg_idx_t REG_ROW_Y_ZW   = reg_idx_t'(3);
	localparam reg_idx_t REG_VIEW_HORIZ = reg_idx_t'(4);
	localparam reg_idx_t REG_VIEW_VERT  = reg_idx_t'(5);

	// Reset values: identity in x and y, zero-size view at the origin
	localparam logic [CFG_W-1:0] ROW_X_XY_RST = 64'h0001_0000_0000_0000;
	localparam logic [CFG_W-1:0] ROW_X_ZW_RST = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] ROW_Y_XY_RST = 64'h0000_0000_0001_0000;
	localparam logic [CFG_W-1:0] ROW_Y_ZW_RST = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] VIEW_RST     = 64'h0000_0000_0000_0000;

	// One box as it sits in the input stage
	typedef struct packed {
		fix_t min_x;
		fix_t min_y;
		fix_t min_z;
		fix_t max_x;
		fix_t max_y;
		fix_t max_z;
	} box_t;

	// Per-stage load enables for the row datapath
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/tbvc_row.sv
`default_nettype none

// One matrix row applied to a box: least and greatest transformed coordinate.
// The row is affine, so its extremes over the eight corners come from picking
// the smaller or larger product per axis and summing those.
module tbvc_row
	import tbvc_pkg::*;
#(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire pipe_ctl_t                    ctl,
	input  wire fix_t                         coef_x,
	input  wire fix_t                         coef_y,
	input  wire fix_t                         coef_z,
	input  wire fix_t                         trans,
	input  wire box_t                         box_s1,
	output logic signed [COORD_BITS-1:0]      lo_s6,
	output logic signed [COORD_BITS-1:0]      hi_s6
);

	localparam int unsigned PROD_W = 2 * FIX_W;
	localparam int unsigned SUM_W  = PROD_W + 2;
	localparam int unsigned ACC_W  = SUM_W + 1;

	localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) <<< (COORD_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

	logic signed [PROD_W-1:0] px0, px1, py0, py1, pz0, pz1;
	logic signed [PROD_W-1:0] px0_s2, px1_s2, py0_s2, py1_s2, pz0_s2, pz1_s2;
	logic signed [PROD_W-1:0] lo_x_s3, hi_x_s3, lo_y_s3, hi_y_s3, lo_z_s3, hi_z_s3;
	logic signed [SUM_W-1:0]  sum_lo_s4, sum_hi_s4;
	logic signed [ACC_W-1:0]  acc_lo_s5, acc_hi_s5;

	// Clamp to the signed coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		begin
			if (v > SAT_MAX) begin
				r = SAT_MAX;
			end else if (v < SAT_MIN) begin
				r = SAT_MIN;
			end else begin
				r = v;
			end
			return r[COORD_BITS-1:0];
		end
	endfunction

	// Form both products per axis
	assign px0 = $signed(coef_x) * $signed(box_s1.min_x);
	assign px1 = $signed(coef_x) * $signed(box_s1.max_x);
	assign py0 = $signed(coef_y) * $signed(box_s1.min_y);
	assign py1 = $signed(coef_y) * $signed(box_s1.max_y);
	assign pz0 = $signed(coef_z) * $signed(box_s1.min_z);
	assign pz1 = $signed(coef_z) * $signed(box_s1.max_z);

	// Register the products
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			px0_s2 <= px0;
			px1_s2 <= px1;
			py0_s2 <= py0;
			py1_s2 <= py1;
			pz0_s2 <= pz0;
			pz1_s2 <= pz1;
		end
	end

	// Sort each axis pair into smaller and larger
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			lo_x_s3 <= (px0_s2 < px1_s2) ? px0_s2 : px1_s2;
			hi_x_s3 <= (px0_s2 < px1_s2) ? px1_s2 : px0_s2;
			lo_y_s3 <= (py0_s2 < py1_s2) ? py0_s2 : py1_s2;
			hi_y_s3 <= (py0_s2 < py1_s2) ? py1_s2 : py0_s2;
			lo_z_s3 <= (pz0_s2 < pz1_s2) ? pz0_s2 : pz1_s2;
			hi_z_s3 <= (pz0_s2 < pz1_s2) ? pz1_s2 : pz0_s2;
		end
	end

	// Sum exactly
	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			sum_lo_s4 <= SUM_W'(lo_x_s3) + SUM_W'(lo_y_s3) + SUM_W'(lo_z_s3);
			sum_hi_s4 <= SUM_W'(hi_x_s3) + SUM_W'(hi_y_s3) + SUM_W'(hi_z_s3);
		end
	end

	// Drop the fraction (floor) and add the translation
	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			acc_lo_s5 <= ACC_W'(sum_lo_s4 >>> FRAC_BITS) + ACC_W'(trans);
			acc_hi_s5 <= ACC_W'(sum_hi_s4 >>> FRAC_BITS) + ACC_W'(trans);
		end
	end

	// Saturate
	always_ff @(posedge clk) begin
		if (ctl.en_s6) begin
			lo_s6 <= sat(acc_lo_s5);
			hi_s6 <= sat(acc_hi_s5);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/transformed_box_viewport_cull.sv
// Transformed bounding-box viewport cull.
// Pipeline registers in order: input register, products, per-axis sort, sum,
// shift and translate, saturate, view test; out_valid comes from the last one.
// Throughput: one box per cycle unless out_stall holds the result; twelve 32x32
// multipliers work in parallel in one stage.
// Reset: asynchronous, active low; clears all stage valids and loads the matrix
// rows to identity in x and y and the view edges to zero.
`default_nettype none

module transformed_box_viewport_cull
	import tbvc_pkg::*;
#(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]       prdata,
	output logic                   pready,
	// Box channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fix_t              box_min_x,
	input  wire fix_t              box_min_y,
	input  wire fix_t              box_min_z,
	input  wire fix_t              box_max_x,
	input  wire fix_t              box_max_y,
	input  wire fix_t              box_max_z,
	// Result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   visible,
	output fix_t                   proj_min_x,
	output fix_t                   proj_max_x,
	output fix_t                   proj_min_y,
	output fix_t                   proj_max_y
);

	localparam int unsigned CMP_W = (COORD_BITS > FIX_W) ? COORD_BITS : FIX_W;

	logic [CFG_W-1:0] row_x_xy_q, row_x_zw_q, row_y_xy_q, row_y_zw_q;
	logic [CFG_W-1:0] view_horiz_q, view_vert_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;
	pipe_ctl_t ctl;

	box_t box_in, box_s1;
	fix_t ax, ay, az, at, cx, cy, cz, ct;
	fix_t left, right, bottom, top;

	logic signed [COORD_BITS-1:0] x_lo_s6, x_hi_s6, y_lo_s6, y_hi_s6;
	logic signed [CMP_W-1:0]      x_lo_e, x_hi_e, y_lo_e, y_hi_e;
	logic signed [CMP_W-1:0]      left_e, right_e, bottom_e, top_e;
	logic                         culled;

	logic visible_s7;
	fix_t proj_min_x_s7, proj_max_x_s7, proj_min_y_s7, proj_max_y_s7;

	// Configuration decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[ADDR_W-1:BYTE_OFS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_xy_q   <= ROW_X_XY_RST;
			row_x_zw_q   <= ROW_X_ZW_RST;
			row_y_xy_q   <= ROW_Y_XY_RST;
			row_y_zw_q   <= ROW_Y_ZW_RST;
			view_horiz_q <= VIEW_RST;
			view_vert_q  <= VIEW_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ROW_X_XY:   row_x_xy_q   <= pwdata;
				REG_ROW_X_ZW:   row_x_zw_q   <= pwdata;
				REG_ROW_Y_XY:   row_y_xy_q   <= pwdata;
				REG_ROW_Y_ZW:   row_y_zw_q   <= pwdata;
				REG_VIEW_HORIZ: view_horiz_q <= pwdata;
				REG_VIEW_VERT:  view_vert_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (cfg_idx)
			REG_ROW_X_XY:   prdata = row_x_xy_q;
			REG_ROW_X_ZW:   prdata = row_x_zw_q;
			REG_ROW_Y_XY:   prdata = row_y_xy_q;
			REG_ROW_Y_ZW:   prdata = row_y_zw_q;
			REG_VIEW_HORIZ: prdata = view_horiz_q;
			REG_VIEW_VERT:  prdata = view_vert_q;
			default:        prdata = '0;
		endcase
	end

	// Split registers into 32-bit halves: Q16.16 coefficients, integer translations and view edges
	assign ax     = row_x_xy_q[CFG_W-1:FIX_W];
	assign ay     = row_x_xy_q[FIX_W-1:0];
	assign az     = row_x_zw_q[CFG_W-1:FIX_W];
	assign at     = row_x_zw_q[FIX_W-1:0];
	assign cx     = row_y_xy_q[CFG_W-1:FIX_W];
	assign cy     = row_y_xy_q[FIX_W-1:0];
	assign cz     = row_y_zw_q[CFG_W-1:FIX_W];
	assign ct     = row_y_zw_q[FIX_W-1:0];
	assign left   = view_horiz_q[CFG_W-1:FIX_W];
	assign right  = view_horiz_q[FIX_W-1:0];
	assign bottom = view_vert_q[CFG_W-1:FIX_W];
	assign top    = view_vert_q[FIX_W-1:0];

	// A stage advances when it is empty or its successor advances
	assign adv_s7 = !vld_s7 || !out_stall;
	assign adv_s6 = !vld_s6 || adv_s7;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;

	assign in_stall = !adv_s1;

	assign ctl.en_s2 = adv_s2;
	assign ctl.en_s3 = adv_s3;
	assign ctl.en_s4 = adv_s4;
	assign ctl.en_s5 = adv_s5;
	assign ctl.en_s6 = adv_s6;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	// Capture the box on transfer
	assign box_in.min_x = box_min_x;
	assign box_in.min_y = box_min_y;
	assign box_in.min_z = box_min_z;
	assign box_in.max_x = box_max_x;
	assign box_in.max_y = box_max_y;
	assign box_in.max_z = box_max_z;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			box_s1 <= box_in;
		end
	end

	// Transform by the x row and the y row
	tbvc_row #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_row_x (
		.clk    (clk),
		.ctl    (ctl),
		.coef_x (ax),
		.coef_y (ay),
		.coef_z (az),
		.trans  (at),
		.box_s1 (box_s1),
		.lo_s6  (x_lo_s6),
		.hi_s6  (x_hi_s6)
	);

	tbvc_row #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_row_y (
		.clk    (clk),
		.ctl    (ctl),
		.coef_x (cx),
		.coef_y (cy),
		.coef_z (cz),
		.trans  (ct),
		.box_s1 (box_s1),
		.lo_s6  (y_lo_s6),
		.hi_s6  (y_hi_s6)
	);

	// Test the projected rectangle against the view
	assign x_lo_e   = CMP_W'(x_lo_s6);
	assign x_hi_e   = CMP_W'(x_hi_s6);
	assign y_lo_e   = CMP_W'(y_lo_s6);
	assign y_hi_e   = CMP_W'(y_hi_s6);
	assign left_e   = CMP_W'(left);
	assign right_e  = CMP_W'(right);
	assign bottom_e = CMP_W'(bottom);
	assign top_e    = CMP_W'(top);

	assign culled = (x_lo_e > right_e) || (y_lo_e > top_e) ||
	                (x_hi_e < left_e) || (y_hi_e < bottom_e);

	// Result register
	always_ff @(posedge clk) begin
		if (adv_s7) begin
			visible_s7    <= !culled;
			proj_min_x_s7 <= x_lo_e[FIX_W-1:0];
			proj_max_x_s7 <= x_hi_e[FIX_W-1:0];
			proj_min_y_s7 <= y_lo_e[FIX_W-1:0];
			proj_max_y_s7 <= y_hi_e[FIX_W-1:0];
		end
	end

	assign out_valid  = vld_s7;
	assign visible    = visible_s7;
	assign proj_min_x = proj_min_x_s7;
	assign proj_max_x = proj_max_x_s7;
	assign proj_min_y = proj_min_y_s7;
	assign proj_max_y = proj_max_y_s7;

	// Input stalls only when every stage is full and the result is held
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 &&
		              vld_s7 && out_stall))
		else $error("input stalled with a free pipeline stage");

	// Projected bounds come out ordered
	a_x_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (x_lo_s6 <= x_hi_s6))
		else $error("projected x minimum above maximum");

	a_y_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (y_lo_s6 <= y_hi_s6))
		else $error("projected y minimum above maximum");

endmodule

`default_nettype wire
